FILE: hdl/pdg_pkg.sv
// Shared types and constants for the pyramid downsample and gradient block.
// Holds the field widths, register codes, reset values and the result record.
// No dependencies.
`default_nettype none

package pdg_pkg;

  // Configuration port
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] SRC_WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] SRC_HEIGHT_RESET = 12'd480;

  // Default size limits of the finer image
  localparam int unsigned MAX_SRC_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_SRC_HEIGHT_DEF = 2048;

  // Payload widths
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned PAIR_W  = 17;
  localparam int unsigned SUM_W   = 18;
  localparam int unsigned GRAD_W  = 19;
  localparam int unsigned COORD_W = 10;

  // Result queue
  localparam int unsigned OFIFO_DEPTH = 8;
  localparam int unsigned OFIFO_PTR_W = 3;
  localparam int unsigned OFIFO_CNT_W = 4;

  // One coarse pixel with its gradients and position
  typedef struct packed {
    logic [SUM_W-1:0]         intensity;
    logic signed [GRAD_W-1:0] grad_h;
    logic signed [GRAD_W-1:0] grad_v;
    logic [COORD_W-1:0]       column;
    logic [COORD_W-1:0]       row;
    logic                     last;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/pdg_ring_mem.sv
// Coarse row ring buffer: one write port and two registered read ports.
// Uses pdg_pkg for the sum width.
`default_nettype none

module pdg_ring_mem #(
  parameter int unsigned DEPTH = 3072,
  parameter int unsigned AW    = 12
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic [pdg_pkg::SUM_W-1:0] wdata_i,
  input  wire logic [AW-1:0]            raddr_a_i,
  input  wire logic [AW-1:0]            raddr_b_i,
  output logic      [pdg_pkg::SUM_W-1:0] rdata_a_o,
  output logic      [pdg_pkg::SUM_W-1:0] rdata_b_o
);

  logic [pdg_pkg::SUM_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports; a read returns the old word on a clash.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

FILE: hdl/pdg_out_fifo.sv
// Result queue that takes up to two results a cycle and hands out one.
// Uses pdg_pkg for the result record and the queue depth.
`default_nettype none

module pdg_out_fifo (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_a_i,
  input  wire pdg_pkg::result_t              data_a_i,
  input  wire logic                          push_b_i,
  input  wire pdg_pkg::result_t              data_b_i,
  input  wire logic                          pop_i,
  output logic                               valid_o,
  output pdg_pkg::result_t                   data_o,
  output logic [pdg_pkg::OFIFO_CNT_W-1:0]    count_o
);

  pdg_pkg::result_t mem [pdg_pkg::OFIFO_DEPTH];

  logic [pdg_pkg::OFIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [pdg_pkg::OFIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [pdg_pkg::OFIFO_CNT_W-1:0] count_q, count_d;
  logic                            any_push;
  logic                            both_push;
  logic                            do_pop;
  pdg_pkg::result_t                slot0_data;
  logic [pdg_pkg::OFIFO_PTR_W-1:0] slot1_ptr;

  // The first result written goes to the write pointer, a second one behind it.
  assign any_push   = push_a_i | push_b_i;
  assign both_push  = push_a_i & push_b_i;
  assign slot0_data = push_a_i ? data_a_i : data_b_i;
  assign slot1_ptr  = wr_ptr_q + pdg_pkg::OFIFO_PTR_W'(1);
  assign do_pop     = pop_i & (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (any_push) begin
      mem[wr_ptr_q] <= slot0_data;
    end
    if (both_push) begin
      mem[slot1_ptr] <= data_b_i;
    end
  end

  // Pointer and fill level bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + pdg_pkg::OFIFO_PTR_W'(push_a_i) + pdg_pkg::OFIFO_PTR_W'(push_b_i);
    rd_ptr_d = rd_ptr_q + pdg_pkg::OFIFO_PTR_W'(do_pop);
    count_d  = count_q + pdg_pkg::OFIFO_CNT_W'(push_a_i) + pdg_pkg::OFIFO_CNT_W'(push_b_i)
               - pdg_pkg::OFIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

FILE: hdl/pyramid_downsample_gradient.sv
// Top level of the pyramid downsample and gradient block.
// Depends on pdg_pkg, pdg_ring_mem and pdg_out_fifo.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+--------------------------------------
//   src     | in        | src_valid_i / src_stall_o  | src_intensity_i
//   res     | out       | res_valid_o / res_stall_i  | level_intensity_o, grad_*_o, pixel_*_o,
//           |           |                            | last_of_run_o
//   cfg     | in        | cfg_we_i (no wait)         | cfg_index_i, cfg_data_i
//
// One source pixel is taken every clock unless stalled. The results of a request go
// through stage 1 and stage 2 into the queue; the ring memory's two read ports serve the
// four neighbour reads, and a completing pixel comes at most every second request.
// Reset clears the counters, the valid flags and the queue and loads the configuration
// defaults; the line buffers hold nothing defined until written, and there is no clearing
// pass. The source is stalled while the queue could not hold the results in the two stages.
`default_nettype none

module pyramid_downsample_gradient #(
  parameter int unsigned MAX_SRC_WIDTH  = pdg_pkg::MAX_SRC_WIDTH_DEF,
  parameter int unsigned MAX_SRC_HEIGHT = pdg_pkg::MAX_SRC_HEIGHT_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [pdg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pdg_pkg::CFG_W-1:0]         cfg_data_i,
  // Source pixels
  input  wire logic                              src_valid_i,
  output logic                                   src_stall_o,
  input  wire logic [pdg_pkg::PIX_W-1:0]         src_intensity_i,
  // Results
  output logic                                   res_valid_o,
  input  wire logic                              res_stall_i,
  output logic [pdg_pkg::SUM_W-1:0]              level_intensity_o,
  output logic signed [pdg_pkg::GRAD_W-1:0]      grad_horizontal_o,
  output logic signed [pdg_pkg::GRAD_W-1:0]      grad_vertical_o,
  output logic [pdg_pkg::COORD_W-1:0]            pixel_column_o,
  output logic [pdg_pkg::COORD_W-1:0]            pixel_row_o,
  output logic                                   last_of_run_o
);

  localparam int unsigned CW      = MAX_SRC_WIDTH / 2;
  localparam int unsigned XI      = $clog2(CW);
  localparam int unsigned RING_D  = 3 * CW;
  localparam int unsigned RAW     = $clog2(RING_D);
  localparam int unsigned FXW     = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned FYW     = $clog2(MAX_SRC_HEIGHT);
  localparam int unsigned WLOG    = $clog2(MAX_SRC_WIDTH + 1);
  localparam int unsigned HLOG    = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int unsigned WDW     = (WLOG > pdg_pkg::CFG_W) ? WLOG : pdg_pkg::CFG_W;
  localparam int unsigned HDW     = (HLOG > pdg_pkg::CFG_W) ? HLOG : pdg_pkg::CFG_W;
  localparam int unsigned QW      = pdg_pkg::OFIFO_CNT_W + 1;
  localparam int unsigned SW      = pdg_pkg::SUM_W;
  localparam int unsigned GW      = pdg_pkg::GRAD_W;
  localparam int unsigned KW      = pdg_pkg::COORD_W;

  // Ring address: row slot times the coarse width plus the column
  function automatic logic [RAW-1:0] ring_addr(input logic [1:0] slot, input logic [XI-1:0] col);
    logic [RAW-1:0] base;
    case (slot)
      2'd0:    base = '0;
      2'd1:    base = RAW'(CW);
      default: base = RAW'(2 * CW);
    endcase
    return base + RAW'(col);
  endfunction

  // ---------------------------------------------------------------- configuration
  logic [pdg_pkg::CFG_W-1:0] cfg_width_q, cfg_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= pdg_pkg::SRC_WIDTH_RESET;
      cfg_height_q <= pdg_pkg::SRC_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pdg_pkg::REG_SRC_WIDTH:  cfg_width_q  <= cfg_data_i;
        pdg_pkg::REG_SRC_HEIGHT: cfg_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective dimensions: zero counts as one, oversize counts as the maximum.
  logic [WDW-1:0]   w_raw, w_dim;
  logic [HDW-1:0]   h_raw, h_dim;
  logic [WDW-2:0]   wl, wl_m1;
  logic [HDW-2:0]   hl;

  always_comb begin
    w_raw = WDW'(cfg_width_q);
    h_raw = HDW'(cfg_height_q);
    if (w_raw == '0) begin
      w_dim = WDW'(1);
    end else if (w_raw > WDW'(MAX_SRC_WIDTH)) begin
      w_dim = WDW'(MAX_SRC_WIDTH);
    end else begin
      w_dim = w_raw;
    end
    if (h_raw == '0) begin
      h_dim = HDW'(1);
    end else if (h_raw > HDW'(MAX_SRC_HEIGHT)) begin
      h_dim = HDW'(MAX_SRC_HEIGHT);
    end else begin
      h_dim = h_raw;
    end
    wl    = w_dim[WDW-1:1];
    hl    = h_dim[HDW-1:1];
    wl_m1 = wl - (WDW-1)'(1);
  end

  // ---------------------------------------------------------------- position counters
  logic [FXW-1:0] fx_q, fx_d;
  logic [FYW-1:0] fy_q, fy_d;
  logic [1:0]     phase_q, phase_d;   // coarse row number modulo three
  logic           src_take;
  logic [WDW-1:0] fx_inc;
  logic [HDW-1:0] fy_inc;
  logic           row_end;

  assign src_take = src_valid_i & ~src_stall_o;

  always_comb begin
    fx_inc  = WDW'(fx_q) + WDW'(1);
    fy_inc  = HDW'(fy_q) + HDW'(1);
    row_end = (fx_inc >= w_dim);
    if (row_end) begin
      fx_d = '0;
      fy_d = (fy_inc >= h_dim) ? '0 : fy_q + FYW'(1);
    end else begin
      fx_d = fx_q + FXW'(1);
      fy_d = (HDW'(fy_q) >= h_dim) ? '0 : fy_q;
    end
    if (fy_d == '0) begin
      phase_d = 2'd0;
    end else if (row_end && fy_q[0]) begin
      phase_d = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
    end else begin
      phase_d = phase_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q    <= '0;
      fy_q    <= '0;
      phase_q <= 2'd0;
    end else if (src_take) begin
      fx_q    <= fx_d;
      fy_q    <= fy_d;
      phase_q <= phase_d;
    end
  end

  // ---------------------------------------------------------------- request decode
  logic [FXW-2:0] cx;
  logic [FYW-2:0] cy;
  logic [XI-1:0]  cx_col;
  logic           in_range;
  logic           right_in_row;
  logic           pair_write;
  logic           sum_event;
  logic [1:0]     slot_cur, slot_mid, slot_top;
  logic [RAW-1:0] a0_addr, b0_addr, right_addr, left_addr, wr_addr;

  always_comb begin
    cx           = fx_q[FXW-1:1];
    cy           = fy_q[FYW-1:1];
    cx_col       = cx[XI-1:0];
    in_range     = ((WDW-1)'(cx) < wl) && ((HDW-1)'(cy) < hl);
    right_in_row = ((WDW-1)'(cx) + (WDW-1)'(1)) < wl;
    pair_write   = src_take & in_range & fx_q[0] & ~fy_q[0];
    sum_event    = src_take & in_range & fx_q[0] & fy_q[0];
    // Row slots of the current, the middle and the oldest coarse row
    slot_cur = phase_q;
    slot_mid = (phase_q == 2'd0) ? 2'd2 : phase_q - 2'd1;
    slot_top = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
    a0_addr  = ring_addr(slot_mid, cx_col);
    b0_addr  = ring_addr(slot_top, cx_col);
    wr_addr  = ring_addr(slot_cur, cx_col);
    // Linear order neighbours wrap to the next and previous coarse rows.
    right_addr = right_in_row ? ring_addr(slot_mid, cx_col + XI'(1))
                              : ring_addr(slot_cur, '0);
    left_addr  = (cx != '0) ? ring_addr(slot_mid, cx_col - XI'(1))
                            : ring_addr(slot_top, wl_m1[XI-1:0]);
  end

  // ---------------------------------------------------------------- pending pixel
  logic [pdg_pkg::PIX_W-1:0]  pending_q;
  logic [pdg_pkg::PAIR_W-1:0] pair_now;

  always_ff @(posedge clk_i) begin
    if (src_take && in_range && !fx_q[0]) begin
      pending_q <= src_intensity_i;
    end
  end

  assign pair_now = pdg_pkg::PAIR_W'(pending_q) + pdg_pkg::PAIR_W'(src_intensity_i);

  // ---------------------------------------------------------------- pair row memory
  logic [pdg_pkg::PAIR_W-1:0] pair_mem [CW];
  logic [pdg_pkg::PAIR_W-1:0] pair_rd_q;

  always_ff @(posedge clk_i) begin
    if (pair_write) begin
      pair_mem[cx_col] <= pair_now;
    end
    pair_rd_q <= pair_mem[cx_col];
  end

  // ---------------------------------------------------------------- stage 1
  logic           s1_valid_q;
  logic [pdg_pkg::PAIR_W-1:0] s1_pix_q;
  logic           s1_mid_q, s1_edge_q, s1_fwd_q;
  logic [RAW-1:0] s1_right_q, s1_left_q, s1_wr_q;
  logic [KW-1:0]  s1_col_q, s1_row_q;
  logic [SW-1:0]  s1_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= sum_event;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_event) begin
      s1_pix_q   <= pair_now;
      s1_mid_q   <= ((FYW-1)'(2) <= cy);
      s1_edge_q  <= (cy == '0) || (((HDW-1)'(cy) + (HDW-1)'(1)) == hl);
      s1_fwd_q   <= !right_in_row && (cx == '0);
      s1_right_q <= right_addr;
      s1_left_q  <= left_addr;
      s1_wr_q    <= wr_addr;
      s1_col_q   <= KW'(cx);
      s1_row_q   <= KW'(cy);
    end
  end

  assign s1_sum = SW'(pair_rd_q) + SW'(s1_pix_q);

  // ---------------------------------------------------------------- ring memory
  logic [RAW-1:0] rd_a_addr, rd_b_addr;
  logic [SW-1:0]  rd_a, rd_b;

  // The second pair of neighbour reads runs in the cycle after the request.
  assign rd_a_addr = s1_valid_q ? s1_right_q : a0_addr;
  assign rd_b_addr = s1_valid_q ? s1_left_q  : b0_addr;

  pdg_ring_mem #(
    .DEPTH (RING_D),
    .AW    (RAW)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (s1_valid_q),
    .waddr_i   (s1_wr_q),
    .wdata_i   (s1_sum),
    .raddr_a_i (rd_a_addr),
    .raddr_b_i (rd_b_addr),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // ---------------------------------------------------------------- stage 2
  logic          s2_valid_q;
  logic [SW-1:0] s2_center_q, s2_up_q, s2_sum_q;
  logic          s2_mid_q, s2_edge_q, s2_fwd_q;
  logic [KW-1:0] s2_col_q, s2_row_q;
  logic [SW-1:0] right_val;
  pdg_pkg::result_t res_mid, res_edge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_center_q <= rd_a;
      s2_up_q     <= rd_b;
      s2_sum_q    <= s1_sum;
      s2_mid_q    <= s1_mid_q;
      s2_edge_q   <= s1_edge_q;
      s2_fwd_q    <= s1_fwd_q;
      s2_col_q    <= s1_col_q;
      s2_row_q    <= s1_row_q;
    end
  end

  // A one-pixel-wide row has its right neighbour in the word written this request.
  assign right_val = s2_fwd_q ? s2_sum_q : rd_a;

  always_comb begin
    res_mid.intensity = s2_center_q;
    res_mid.grad_h    = $signed({1'b0, right_val}) - $signed({1'b0, rd_b});
    res_mid.grad_v    = $signed({1'b0, s2_sum_q}) - $signed({1'b0, s2_up_q});
    res_mid.column    = s2_col_q;
    res_mid.row       = s2_row_q - KW'(1);
    res_mid.last      = ~s2_edge_q;

    res_edge.intensity = s2_sum_q;
    res_edge.grad_h    = '0;
    res_edge.grad_v    = '0;
    res_edge.column    = s2_col_q;
    res_edge.row       = s2_row_q;
    res_edge.last      = 1'b1;
  end

  // ---------------------------------------------------------------- result queue
  logic [pdg_pkg::OFIFO_CNT_W-1:0] q_count;
  logic [QW-1:0]                   q_need;
  pdg_pkg::result_t                q_data;

  pdg_out_fifo u_ofifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (s2_valid_q & s2_mid_q),
    .data_a_i (res_mid),
    .push_b_i (s2_valid_q & s2_edge_q),
    .data_b_i (res_edge),
    .pop_i    (~res_stall_i),
    .valid_o  (res_valid_o),
    .data_o   (q_data),
    .count_o  (q_count)
  );

  // Room must remain for two results of every request still in flight and of one more.
  assign q_need = QW'(q_count) + (QW'(s1_valid_q) << 1) + (QW'(s2_valid_q) << 1);
  assign src_stall_o = (q_need > QW'(pdg_pkg::OFIFO_DEPTH - 2));

  assign level_intensity_o = q_data.intensity;
  assign grad_horizontal_o = q_data.grad_h;
  assign grad_vertical_o   = q_data.grad_v;
  assign pixel_column_o    = q_data.column;
  assign pixel_row_o       = q_data.row;
  assign last_of_run_o     = q_data.last;

endmodule

`default_nettype wire
